[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Property checked on every rising edge, reset included.
`define ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

[rtl/ddo_pkg.sv]
// Package with types, constants and tables of the odometry block.
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CNT_W            = 7;
    localparam int DIV_STEPS        = 64;
    localparam int XW               = 52;
    localparam int ZW               = 34;
    localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;
    localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
    localparam logic [0:0]  REG_HEADING  = 1'b0;
    localparam logic [0:0]  REG_DISTANCE = 1'b1;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic [31:0]        time_sec;
        logic [29:0]        time_nsec;
    } ddo_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        heading_angle;
        logic               time_fault;
    } ddo_out_t;

    typedef struct packed {
        logic [31:0] heading_gain;
        logic [31:0] distance_gain;
    } ddo_cfg_t;

    typedef struct packed {
        logic load_in;
        logic mul_gain;
        logic gain_lo;
        logic gain_hi;
        logic fold;
        logic rot;
        logic pos;
        logic div_set;
        logic div_step;
        logic div_store;
        logic out_load;
        logic lane;
    } ddo_cmd_t;

    typedef struct packed {
        logic fault;
    } ddo_status_t;

    // Binary-angle arctangent of 2^-i.
    function automatic logic [31:0] atan_at(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/diff_drive_odometry.sv]
// Two-wheel odometry: each word passes through the gain steps, the one-step CORDIC
// loop and the radix-2 divider, which runs 64 steps for each of the two velocities;
// the divider is skipped when the interval is not positive.
// A new word is taken only once the previous one has reached the output register, and
// that load waits while a shown result has not yet been taken.
// Reset (rst_n low, asynchronous) clears counts, position, heading, timestamp and gains.
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ddo_pkg::ddo_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ddo_pkg::ddo_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ddo_pkg::*;

    ddo_cfg_t    cfg;
    ddo_cmd_t    cmd;
    ddo_status_t status;
    logic [4:0]  iter;

    assign pready = 1'b1;

    // Configuration registers.
    ddo_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Sequencer.
    ddo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .iter      (iter)
    );

    // Arithmetic.
    ddo_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg      (cfg),
        .cmd      (cmd),
        .iter     (iter),
        .status   (status),
        .out_data (out_data)
    );
endmodule

[rtl/ddo_regs.sv]
// Configuration register file behind the APB-style port.
module ddo_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output ddo_pkg::ddo_cfg_t cfg
);
    import ddo_pkg::*;

    logic [31:0] heading_gain_reg;
    logic [31:0] distance_gain_reg;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_gain_reg  <= '0;
            distance_gain_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_HEADING:  heading_gain_reg  <= pwdata;
                REG_DISTANCE: distance_gain_reg <= pwdata;
                default:      heading_gain_reg  <= heading_gain_reg;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        case (paddr[2])
            REG_HEADING:  prdata = heading_gain_reg;
            REG_DISTANCE: prdata = distance_gain_reg;
            default:      prdata = '0;
        endcase
    end

    assign cfg.heading_gain  = heading_gain_reg;
    assign cfg.distance_gain = distance_gain_reg;
endmodule

[rtl/ddo_ctrl.sv]
// Sequencer that steps the odometry datapath through one word.
module ddo_ctrl #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ddo_pkg::ddo_status_t status,
    output ddo_pkg::ddo_cmd_t    cmd,
    output logic [4:0]           iter
);
    import ddo_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_MUL    = 11'b00000000010,
        S_GLO    = 11'b00000000100,
        S_GHI    = 11'b00000001000,
        S_FOLD   = 11'b00000010000,
        S_ROT    = 11'b00000100000,
        S_POS    = 11'b00001000000,
        S_DSET   = 11'b00010000000,
        S_DRUN   = 11'b00100000000,
        S_DSTORE = 11'b01000000000,
        S_OUTW   = 11'b10000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               lane_reg, lane_next;
    logic               out_valid_reg, out_valid_next;
    logic               slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign iter      = cnt_reg[4:0];

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        lane_next      = lane_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.lane       = lane_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_gain = 1'b1;
                state_next   = S_GLO;
            end
            S_GLO:
            begin
                cmd.gain_lo = 1'b1;
                state_next  = S_GHI;
            end
            S_GHI:
            begin
                cmd.gain_hi = 1'b1;
                state_next  = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                cnt_next   = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                cmd.pos    = 1'b1;
                lane_next  = 1'b0;
                state_next = S_DSET;
            end
            S_DSET:
            begin
                // A non-positive interval leaves both velocities at zero.
                if (status.fault)
                begin
                    state_next = S_OUTW;
                end
                else
                begin
                    cmd.div_set = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_DRUN;
                end
            end
            S_DRUN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DSTORE;
                end
            end
            S_DSTORE:
            begin
                cmd.div_store = 1'b1;
                if (lane_reg)
                begin
                    state_next = S_OUTW;
                end
                else
                begin
                    lane_next  = 1'b1;
                    state_next = S_DSET;
                end
            end
            S_OUTW:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            lane_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

[rtl/ddo_dpath.sv]
// Datapath: deltas, gains, CORDIC rotation, position and serial divider.
module ddo_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ddo_pkg::ddo_in_t     in_data,
    input  ddo_pkg::ddo_cfg_t    cfg,
    input  ddo_pkg::ddo_cmd_t    cmd,
    input  logic [4:0]           iter,
    output ddo_pkg::ddo_status_t status,
    output ddo_pkg::ddo_out_t    out_data
);
    import ddo_pkg::*;

    // Architectural state.
    logic [31:0]        last_left_reg, last_right_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg;
    logic [31:0]        heading_reg;
    logic [63:0]        last_time_reg;

    // Working registers.
    logic signed [32:0]   diff_reg;
    logic [32:0]          abs_sum_reg;
    logic                 sum_neg_reg;
    logic [63:0]          dt_reg;
    logic [47:0]          d_reg;
    logic [63:0]          plo_reg;
    logic [47:0]          s_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [32:0]   dpos_x_reg, dpos_y_reg;
    logic [63:0]          num_reg, rem_reg;
    logic                 neg_reg;
    logic signed [31:0]   vel_x_reg, vel_y_reg;
    ddo_out_t             out_reg;

    logic signed [31:0] dl, dr;
    logic signed [32:0] sum33;
    logic [63:0]        tnow;
    logic signed [65:0] hprod;
    logic [47:0]        hround;
    logic [64:0]        dprod, dround;
    logic [47:0]        phi;
    logic [64:0]        plo_r;
    logic signed [XW-1:0] xs0;
    logic                 flip;
    logic [31:0]          th;
    logic signed [XW-1:0] xsh, ysh;
    logic signed [ZW-1:0] at;
    logic signed [XW:0]   sumx, sumy;
    logic signed [31:0]   newx, newy;
    logic signed [32:0]   dpos;
    logic [32:0]          mag;
    logic [62:0]          magns;
    logic [63:0]          rem_sh;
    logic                 ge;
    logic signed [31:0]   vel;

    function automatic logic signed [31:0] sat32(input logic signed [XW:0] v);
        logic signed [31:0] r;
        if (v > $signed((XW+1)'(32'sh7FFFFFFF)))
            r = 32'sh7FFFFFFF;
        else if (v < -$signed((XW+1)'(33'sh080000000)))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Input deltas and timestamp.
    always_comb
    begin
        dl    = in_data.left_count - $signed(last_left_reg);
        dr    = in_data.right_count - $signed(last_right_reg);
        sum33 = {dr[31], dr} + {dl[31], dl};
        tnow  = 64'(in_data.time_sec * NS_PER_SEC) + 64'(in_data.time_nsec);
    end

    // Gain products.
    always_comb
    begin
        hprod  = diff_reg * $signed({1'b0, cfg.heading_gain});
        hround = hprod[47:0] + 48'h8000;
        dprod  = abs_sum_reg * cfg.distance_gain;
        dround = dprod + 65'h8000;
        phi    = d_reg[47:32] * CORDIC_GAIN;
        plo_r  = {1'b0, plo_reg} + 65'h80000000;
    end

    // Quadrant fold and one CORDIC micro-rotation.
    always_comb
    begin
        xs0  = $signed({4'b0, s_reg});
        flip = (heading_reg[31:30] == 2'b01) || (heading_reg[31:30] == 2'b10);
        th   = flip ? (heading_reg ^ 32'h80000000) : heading_reg;
        xsh  = x_reg >>> iter;
        ysh  = y_reg >>> iter;
        at   = $signed({2'b0, atan_at(iter)});
    end

    // Saturating position update.
    always_comb
    begin
        sumx = $signed({{(XW-31){acc_x_reg[31]}}, acc_x_reg}) + {x_reg[XW-1], x_reg};
        sumy = $signed({{(XW-31){acc_y_reg[31]}}, acc_y_reg}) + {y_reg[XW-1], y_reg};
        newx = sat32(sumx);
        newy = sat32(sumy);
    end

    // Divider setup, step and result saturation.
    always_comb
    begin
        dpos   = cmd.lane ? dpos_y_reg : dpos_x_reg;
        mag    = dpos[32] ? 33'(-dpos) : 33'(dpos);
        magns  = 63'(mag * NS_PER_SEC);
        rem_sh = {rem_reg[62:0], num_reg[63]};
        ge     = (rem_sh >= dt_reg);
        if (neg_reg)
            vel = (num_reg > 64'h80000000) ? 32'sh80000000 : $signed(32'(-num_reg[31:0]));
        else
            vel = (num_reg > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(num_reg[31:0]);
    end

    assign status.fault = ($signed(dt_reg) <= 64'sd0);
    assign out_data     = out_reg;

    // State registers cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_reg  <= '0;
            last_right_reg <= '0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            heading_reg    <= '0;
            last_time_reg  <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                last_left_reg  <= in_data.left_count;
                last_right_reg <= in_data.right_count;
                last_time_reg  <= tnow;
            end
            if (cmd.mul_gain)
            begin
                heading_reg <= heading_reg + hround[47:16];
            end
            if (cmd.pos)
            begin
                acc_x_reg <= newx;
                acc_y_reg <= newy;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            diff_reg    <= {dr[31], dr} - {dl[31], dl};
            abs_sum_reg <= sum33[32] ? 33'(-sum33) : 33'(sum33);
            sum_neg_reg <= sum33[32];
            dt_reg      <= tnow - last_time_reg;
        end
        if (cmd.mul_gain)
        begin
            d_reg <= dround[63:16];
        end
        if (cmd.gain_lo)
        begin
            plo_reg <= d_reg[31:0] * CORDIC_GAIN;
        end
        if (cmd.gain_hi)
        begin
            s_reg <= phi + 48'(plo_r[64:32]);
        end
        if (cmd.fold)
        begin
            x_reg <= (sum_neg_reg ^ flip) ? -xs0 : xs0;
            y_reg <= '0;
            z_reg <= $signed({{(ZW-32){th[31]}}, th});
        end
        if (cmd.rot)
        begin
            if (!z_reg[ZW-1])
            begin
                x_reg <= x_reg - ysh;
                y_reg <= y_reg + xsh;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ysh;
                y_reg <= y_reg - xsh;
                z_reg <= z_reg + at;
            end
        end
        if (cmd.pos)
        begin
            dpos_x_reg <= {newx[31], newx} - {acc_x_reg[31], acc_x_reg};
            dpos_y_reg <= {newy[31], newy} - {acc_y_reg[31], acc_y_reg};
            vel_x_reg  <= '0;
            vel_y_reg  <= '0;
        end
        if (cmd.div_set)
        begin
            num_reg <= {1'b0, magns} + {1'b0, dt_reg[63:1]};
            rem_reg <= '0;
            neg_reg <= dpos[32];
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? (rem_sh - dt_reg) : rem_sh;
            num_reg <= {num_reg[62:0], ge};
        end
        if (cmd.div_store)
        begin
            if (cmd.lane)
                vel_y_reg <= vel;
            else
                vel_x_reg <= vel;
        end
        if (cmd.out_load)
        begin
            out_reg.pos_x         <= acc_x_reg;
            out_reg.pos_y         <= acc_y_reg;
            out_reg.vel_x         <= vel_x_reg;
            out_reg.vel_y         <= vel_y_reg;
            out_reg.heading_angle <= heading_reg;
            out_reg.time_fault    <= status.fault;
        end
    end
endmodule

[rtl/ddo_checker.sv]
// Port-level checker for the odometry block, bound to the top level.
`include "assert_macros.svh"
module ddo_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input ddo_pkg::ddo_out_t out_data
);
    import ddo_pkg::*;

    // Only one word is in flight at a time.
    `ASSERT_CLK(a_one_in_flight, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
    // A stalled result holds.
    `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    // A timing fault reports zero velocity.
    `ASSERT_CLK(a_fault_zero, clk, rst_n, (out_valid && out_data.time_fault) |-> ((out_data.vel_x == 32'sd0) && (out_data.vel_y == 32'sd0)))
    // No result is shown during reset.
    `ASSERT_ANY(a_reset_quiet, clk, !rst_n |-> !out_valid)
endmodule

bind diff_drive_odometry ddo_checker u_chk (.*);
